// ----- hw/rtl/priority_five_tuple_policy_classifier_assert.svh -----
// assertion macros for the policy classifier
`ifndef PRIORITY_FIVE_TUPLE_POLICY_CLASSIFIER_ASSERT_SVH
`define PRIORITY_FIVE_TUPLE_POLICY_CLASSIFIER_ASSERT_SVH
// property that must hold at every clock edge out of reset
`define PFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

// ----- hw/rtl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// types and constants shared by the policy classifier
// ----------------------------------------------------------------------------
`default_nettype none
package pfc_pkg;
  localparam int RuleCount = 64;
  localparam int IdxW = 6;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [2:0] WordCount = 3'd5;

  typedef enum logic [1:0] {
    PATH_DLP = 2'd0,
    PATH_CLASSIFY = 2'd1,
    PATH_DROP = 2'd2
  } path_t;

  typedef enum logic [1:0] {
    CFG_DLP_DEFAULT = 2'd0,
    CFG_DENY_CODE = 2'd1,
    CFG_INSPECT_CODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // packet key travelling along the chain
  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [7:0] proto;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] tenant;
  } key_t;

  // running best match travelling beside the key
  typedef struct packed {
    logic found;
    logic [31:0] pri;
    logic [IdxW-1:0] idx;
    logic [31:0] id;
    logic [7:0] action;
    logic [7:0] qos;
  } best_t;

  // write request broadcast to every cell
  typedef struct packed {
    logic en;
    logic [IdxW-1:0] idx;
    logic [2:0] sel;
    logic [63:0] data;
  } wr_t;

  function automatic logic prefix_hit(logic [31:0] a, logic [31:0] p, logic [7:0] len);
    logic [31:0] mask;
    logic [5:0] l;
    l = (len > 8'd32) ? 6'd32 : len[5:0];
    mask = (l == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - l));
    return (len == 8'd0) || ((a & mask) == (p & mask));
  endfunction

  function automatic logic range_hit(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
    return ((lo == 16'd0) && (hi == 16'd0)) || ((p >= lo) && (p <= hi));
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/pfc_if.sv -----
// ----------------------------------------------------------------------------
// pfc channel interfaces
// valid/ready channels for packets and rule writes, results and configuration
// ----------------------------------------------------------------------------
`default_nettype none
interface pfc_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [5:0] rule_index;
  logic [2:0] word_select;
  logic [63:0] word_data;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0] ip_protocol;
  logic [15:0] raw_src_port;
  logic [15:0] raw_dst_port;
  logic [31:0] packet_tenant;
  modport source (output valid, op, rule_index, word_select, word_data, src_addr, dst_addr,
                  ip_protocol, raw_src_port, raw_dst_port, packet_tenant, input ready);
  modport sink (input valid, op, rule_index, word_select, word_data, src_addr, dst_addr,
                ip_protocol, raw_src_port, raw_dst_port, packet_tenant, output ready);
endinterface

interface pfc_out_if;
  logic valid;
  logic ready;
  logic [1:0] next_path;
  logic matched;
  logic [5:0] matched_rule;
  logic [31:0] policy_id_out;
  logic [7:0] qos_class_out;
  modport source (output valid, next_path, matched, matched_rule, policy_id_out,
                  qos_class_out, input ready);
  modport sink (input valid, next_path, matched, matched_rule, policy_id_out,
                qos_class_out, output ready);
endinterface

interface pfc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pfc_cell.sv -----
// ----------------------------------------------------------------------------
// pfc_cell
// one rule slot: holds its rule, matches the passing key, updates the best
// ----------------------------------------------------------------------------
`default_nettype none
module pfc_cell
  import pfc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [IdxW-1:0] my_idx,
  input wire wr_t wr,
  input wire key_t key_in,
  input wire best_t best_in,
  output key_t key_out,
  output best_t best_out
);
  logic [63:0] w_r [WordCount];
  logic hit;
  logic used;
  logic [31:0] pri;
  best_t best_nxt;

  // rule word storage, cleared so the slot starts unused
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '{default: '0};
    end else if (wr.en && wr.idx == my_idx && wr.sel < WordCount) begin
      w_r[wr.sel] <= wr.data;
    end
  end

  // match and compare against the running best
  always_comb begin
    pri = w_r[0][31:0];
    used = (w_r[0] != 64'd0);
    hit = used
      && (w_r[1][63:32] == 32'd0 || w_r[1][63:32] == key_in.tenant)
      && prefix_hit(key_in.sa, w_r[1][31:0], w_r[2][31:24])
      && prefix_hit(key_in.da, w_r[2][63:32], w_r[2][23:16])
      && (w_r[2][15:8] == 8'd0 || w_r[2][15:8] == key_in.proto)
      && range_hit(key_in.sp, w_r[3][63:48], w_r[3][47:32])
      && range_hit(key_in.dp, w_r[3][31:16], w_r[3][15:0]);
    best_nxt = best_in;
    if (hit && pri < best_in.pri) begin
      best_nxt.found = 1'b1;
      best_nxt.pri = pri;
      best_nxt.idx = my_idx;
      best_nxt.id = w_r[0][63:32];
      best_nxt.action = w_r[4][15:8];
      best_nxt.qos = w_r[4][7:0];
    end
  end

  assign key_out = key_in;
  assign best_out = best_nxt;
endmodule
`default_nettype wire

// ----- hw/rtl/pfc_chain.sv -----
// ----------------------------------------------------------------------------
// pfc_chain
// row of rule cells with a register stage after every cell
// ----------------------------------------------------------------------------
`default_nettype none
module pfc_chain
  import pfc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire wr_t wr,
  input wire key_t key_in,
  output best_t best_out
);
  key_t key_r [RuleCount+1];
  best_t best_r [RuleCount+1];
  key_t key_c [RuleCount];
  best_t best_c [RuleCount];
  best_t seed;

  // empty best entering the head of the chain
  always_comb begin
    seed = '0;
    seed.pri = 32'hFFFF_FFFF;
  end

  assign key_r[0] = key_in;
  assign best_r[0] = seed;

  for (genvar g = 0; g < RuleCount; g++) begin : g_cell
    pfc_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IdxW'(g)), .wr(wr),
      .key_in(key_r[g]), .best_in(best_r[g]),
      .key_out(key_c[g]), .best_out(best_c[g])
    );
    // hand the key and best on to the neighbour
    always_ff @(posedge clk) begin
      key_r[g+1] <= key_c[g];
      best_r[g+1] <= best_c[g];
    end
  end

  assign best_out = best_r[RuleCount];
endmodule
`default_nettype wire

// ----- hw/rtl/priority_five_tuple_policy_classifier.sv -----
// ----------------------------------------------------------------------------
// priority_five_tuple_policy_classifier
// 64-rule five-tuple classifier, lowest priority value wins
// ----------------------------------------------------------------------------
// A packet request travels along a row of 64 rule cells, one cell per clock,
// and its result is registered at the end of the chain and then offered; one
// request is handled at a time, so no new request is taken until it is accepted.
// A rule word write is stored on acceptance and gives no result.
`default_nettype none
module priority_five_tuple_policy_classifier
  import pfc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  pfc_in_if.sink in_ch,
  pfc_out_if.source out_ch,
  pfc_cfg_if.sink cfg_ch
);
  state_t state_r, state_nxt;
  logic [IdxW:0] cnt_r, cnt_nxt;
  logic dlp_r;
  logic [7:0] deny_r, insp_r;
  wr_t wr;
  key_t key;
  best_t best;
  logic in_acc;
  logic [1:0] path_r;
  logic match_r;
  logic [5:0] rule_r;
  logic [31:0] id_r;
  logic [7:0] qos_r;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlp_r <= 1'b1;
      deny_r <= 8'd1;
      insp_r <= 8'd2;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_DLP_DEFAULT: dlp_r <= cfg_ch.data[0];
        CFG_DENY_CODE: deny_r <= cfg_ch.data;
        CFG_INSPECT_CODE: insp_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // write request and packet key
  always_comb begin
    wr.en = in_acc && in_ch.op;
    wr.idx = in_ch.rule_index;
    wr.sel = in_ch.word_select;
    wr.data = in_ch.word_data;
    key.sa = in_ch.src_addr;
    key.da = in_ch.dst_addr;
    key.proto = in_ch.ip_protocol;
    key.tenant = in_ch.packet_tenant;
    if (in_ch.ip_protocol == ProtoTcp || in_ch.ip_protocol == ProtoUdp) begin
      key.sp = in_ch.raw_src_port;
      key.dp = in_ch.raw_dst_port;
    end else begin
      key.sp = 16'd0;
      key.dp = 16'd0;
    end
  end

  pfc_chain u_chain (.clk(clk), .rst_n(rst_n), .wr(wr), .key_in(key), .best_out(best));

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && !in_ch.op) begin
        state_nxt = ST_SCAN;
        cnt_nxt = '0;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (IdxW+1)'(RuleCount - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result capture at the end of the chain
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && cnt_r == (IdxW+1)'(RuleCount - 1)) begin
      match_r <= best.found;
      if (best.found) begin
        rule_r <= best.idx;
        id_r <= best.id;
        qos_r <= best.qos;
        if (best.action == deny_r) path_r <= PATH_DROP;
        else if (best.action == insp_r) path_r <= PATH_DLP;
        else path_r <= PATH_CLASSIFY;
      end else begin
        rule_r <= '0;
        id_r <= '0;
        qos_r <= '0;
        path_r <= dlp_r ? PATH_DLP : PATH_CLASSIFY;
      end
    end
  end

  // outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_DONE);
    out_ch.next_path = path_r;
    out_ch.matched = match_r;
    out_ch.matched_rule = rule_r;
    out_ch.policy_id_out = id_r;
    out_ch.qos_class_out = qos_r;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pfc_checker.sv -----
// ----------------------------------------------------------------------------
// pfc_checker
// port-level checks on the classifier
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_five_tuple_policy_classifier_assert.svh"
module pfc_checker
  import pfc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic matched,
  input wire logic [5:0] matched_rule,
  input wire logic [1:0] next_path
);
  `PFC_ASSERT(a_no_in_while_out, out_valid |-> !in_ready, "request taken while result pending")
  `PFC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `PFC_ASSERT(a_unmatched_zero, out_valid && !matched |-> matched_rule == 6'd0, "bad rule")
  `PFC_ASSERT(a_path_legal, out_valid |-> next_path != 2'd3, "bad path")
endmodule

bind priority_five_tuple_policy_classifier pfc_checker u_pfc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .matched(out_ch.matched),
  .matched_rule(out_ch.matched_rule), .next_path(out_ch.next_path)
);
`default_nettype wire
